@@ hw/rtl/rtch_pkg.sv @@
// Shared types, constants and the product-term sequence of the closest-hit unit.
package rtch_pkg;

  localparam int COORD_W   = 32;
  localparam int DIST_W    = 31;
  localparam int IDX_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Triangle index wraps at the smaller of this and 2^IDX_W
  localparam int MAX_TRIANGLES = 65536;
  localparam int TRI_LIMIT     = (MAX_TRIANGLES < 65536) ? MAX_TRIANGLES : 65536;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd6;

  // Datapath widths
  localparam int SV_W   = 33;           // short operand: dir, e1, e2, s
  localparam int LV_W   = 68;           // long operand: e1, e2, p, q
  localparam int HALF_W = 34;           // long operand is used in two halves
  localparam int PROD_W = SV_W + HALF_W + 1;
  localparam int ACC_W  = 104;
  localparam int P_W    = 66;
  localparam int Q_W    = 67;
  localparam int N_W    = 102;          // det, unum, vnum, tnum
  localparam int SAT_W  = N_W + 15;
  localparam int REM_W  = N_W + 1;
  localparam int QUO_W  = DIST_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int NUM_TERMS = 24;
  localparam int TERM_W    = $clog2(NUM_TERMS);
  localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(NUM_TERMS - 1);

  // Operand kinds and vector components
  localparam logic [1:0] SK_DIR = 2'd0;
  localparam logic [1:0] SK_E1  = 2'd1;
  localparam logic [1:0] SK_E2  = 2'd2;
  localparam logic [1:0] SK_S   = 2'd3;
  localparam logic [1:0] LK_E1  = 2'd0;
  localparam logic [1:0] LK_E2  = 2'd1;
  localparam logic [1:0] LK_P   = 2'd2;
  localparam logic [1:0] LK_Q   = 2'd3;
  localparam logic [1:0] CX     = 2'd0;
  localparam logic [1:0] CY     = 2'd1;
  localparam logic [1:0] CZ     = 2'd2;

  // Accumulator destinations
  localparam logic [3:0] DST_NONE = 4'd0;
  localparam logic [3:0] DST_P0   = 4'd1;
  localparam logic [3:0] DST_P1   = 4'd2;
  localparam logic [3:0] DST_P2   = 4'd3;
  localparam logic [3:0] DST_Q0   = 4'd4;
  localparam logic [3:0] DST_Q1   = 4'd5;
  localparam logic [3:0] DST_Q2   = 4'd6;
  localparam logic [3:0] DST_DET  = 4'd7;
  localparam logic [3:0] DST_UNUM = 4'd8;
  localparam logic [3:0] DST_VNUM = 4'd9;
  localparam logic [3:0] DST_TNUM = 4'd10;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic                      last_triangle;
  } tri_in_t;

  typedef struct packed {
    logic              hit_found;
    logic [DIST_W-1:0] hit_distance;
    logic [IDX_W-1:0]  hit_triangle;
  } hit_out_t;

  typedef struct packed {
    logic [1:0] s_kind;
    logic [1:0] s_comp;
    logic [1:0] l_kind;
    logic [1:0] l_comp;
    logic       neg;
    logic       first;
    logic [3:0] dest;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              mul_hi;
    logic [TERM_W-1:0] term;
    logic              norm;
    logic              check;
    logic              div_step;
    logic              update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic last;
    logic out_busy;
  } dp_status_t;

  function automatic uop_t mk_uop(input logic [1:0] sk, input logic [1:0] sc,
                                  input logic [1:0] lk, input logic [1:0] lc,
                                  input logic neg, input logic first,
                                  input logic [3:0] dest);
    uop_t u;
    u.s_kind = sk;
    u.s_comp = sc;
    u.l_kind = lk;
    u.l_comp = lc;
    u.neg    = neg;
    u.first  = first;
    u.dest   = dest;
    return u;
  endfunction

  // p = dir x e2, det = e1.p, q = s x e1, unum = s.p, vnum = dir.q, tnum = e2.q
  function automatic uop_t uop_rom(input logic [TERM_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = mk_uop(SK_DIR, CY, LK_E2, CZ, 1'b0, 1'b1, DST_NONE);
      5'd1:  u = mk_uop(SK_DIR, CZ, LK_E2, CY, 1'b1, 1'b0, DST_P0);
      5'd2:  u = mk_uop(SK_DIR, CZ, LK_E2, CX, 1'b0, 1'b1, DST_NONE);
      5'd3:  u = mk_uop(SK_DIR, CX, LK_E2, CZ, 1'b1, 1'b0, DST_P1);
      5'd4:  u = mk_uop(SK_DIR, CX, LK_E2, CY, 1'b0, 1'b1, DST_NONE);
      5'd5:  u = mk_uop(SK_DIR, CY, LK_E2, CX, 1'b1, 1'b0, DST_P2);
      5'd6:  u = mk_uop(SK_E1,  CX, LK_P,  CX, 1'b0, 1'b1, DST_NONE);
      5'd7:  u = mk_uop(SK_E1,  CY, LK_P,  CY, 1'b0, 1'b0, DST_NONE);
      5'd8:  u = mk_uop(SK_E1,  CZ, LK_P,  CZ, 1'b0, 1'b0, DST_DET);
      5'd9:  u = mk_uop(SK_S,   CY, LK_E1, CZ, 1'b0, 1'b1, DST_NONE);
      5'd10: u = mk_uop(SK_S,   CZ, LK_E1, CY, 1'b1, 1'b0, DST_Q0);
      5'd11: u = mk_uop(SK_S,   CZ, LK_E1, CX, 1'b0, 1'b1, DST_NONE);
      5'd12: u = mk_uop(SK_S,   CX, LK_E1, CZ, 1'b1, 1'b0, DST_Q1);
      5'd13: u = mk_uop(SK_S,   CX, LK_E1, CY, 1'b0, 1'b1, DST_NONE);
      5'd14: u = mk_uop(SK_S,   CY, LK_E1, CX, 1'b1, 1'b0, DST_Q2);
      5'd15: u = mk_uop(SK_S,   CX, LK_P,  CX, 1'b0, 1'b1, DST_NONE);
      5'd16: u = mk_uop(SK_S,   CY, LK_P,  CY, 1'b0, 1'b0, DST_NONE);
      5'd17: u = mk_uop(SK_S,   CZ, LK_P,  CZ, 1'b0, 1'b0, DST_UNUM);
      5'd18: u = mk_uop(SK_DIR, CX, LK_Q,  CX, 1'b0, 1'b1, DST_NONE);
      5'd19: u = mk_uop(SK_DIR, CY, LK_Q,  CY, 1'b0, 1'b0, DST_NONE);
      5'd20: u = mk_uop(SK_DIR, CZ, LK_Q,  CZ, 1'b0, 1'b0, DST_VNUM);
      5'd21: u = mk_uop(SK_E2,  CX, LK_Q,  CX, 1'b0, 1'b1, DST_NONE);
      5'd22: u = mk_uop(SK_E2,  CY, LK_Q,  CY, 1'b0, 1'b0, DST_NONE);
      5'd23: u = mk_uop(SK_E2,  CZ, LK_Q,  CZ, 1'b0, 1'b0, DST_TNUM);
      default: u = mk_uop(SK_DIR, CX, LK_E1, CX, 1'b0, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/rtch_ctrl.sv @@
// Sequencer of the closest-hit unit: product terms, sign fix, checks, division, update.
module rtch_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output rtch_pkg::ctrl_cmd_t    cmd,
  input  rtch_pkg::dp_status_t   status
);
  import rtch_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_NORM   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [TERM_W-1:0]    term;
  logic                 half;
  logic [DIV_CNT_W-1:0] div_cnt;

  assign in_stall = (state != ST_IDLE);

  // Next state and per-cycle commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.term     = term;
    cmd.mul_hi   = half;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (half && term == LAST_TERM) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_NORM;
      ST_NORM: begin
        cmd.norm   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_needed) begin
          cmd.div_step = 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_UPDATE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // a final result waits for the output register to free up
        if (!(status.last && status.out_busy)) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      term    <= '0;
      half    <= 1'b0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        term <= '0;
        half <= 1'b0;
      end else if (cmd.mul_en) begin
        half <= ~half;
        if (half) term <= term + 1'b1;
      end
      if (cmd.check) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_starts_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_MUL) else $error("accepted transaction did not start products");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < DIV_CNT_W'(DIV_STEPS)) else $error("divider overran");
  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DRAIN) |-> $past(term) == LAST_TERM && $past(half))
    else $error("product sequence cut short");
`endif
endmodule

@@ hw/rtl/rtch_datapath.sv @@
// Datapath of the closest-hit unit: ray registers, shared multiplier, divider, best hit.
module rtch_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rtch_pkg::ctrl_cmd_t           cmd,
  output rtch_pkg::dp_status_t          status,
  input  rtch_pkg::tri_in_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rtch_pkg::hit_out_t            out_data,
  input  logic                          cfg_we,
  input  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtch_pkg::COORD_W-1:0]  cfg_data
);
  import rtch_pkg::*;

  // Ray registers
  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
  logic [DIST_W-1:0]         min_distance;

  // Per-triangle operands and results
  logic signed [SV_W-1:0] e1_x, e1_y, e1_z, e2_x, e2_y, e2_z, s_x, s_y, s_z;
  logic signed [P_W-1:0]  p_x, p_y, p_z;
  logic signed [Q_W-1:0]  q_x, q_y, q_z;
  logic signed [N_W-1:0]  det, unum, vnum, tnum;
  logic signed [N_W-1:0]  det_a, u_a, v_a, t_a;
  logic                   last_r;

  // Multiplier and accumulator
  uop_t                    uop;
  logic signed [SV_W-1:0]  sv;
  logic signed [LV_W-1:0]  lv;
  logic signed [HALF_W:0]  half_op;
  logic signed [PROD_W-1:0] prod_r;
  logic                    t_valid, t_hi, t_neg, t_first;
  logic [3:0]              t_dest;
  logic signed [ACC_W-1:0] acc, addend, base, acc_new;

  // Checks and divider
  logic                    pass_r, sat_r;
  logic signed [N_W:0]     uv_sum;
  logic                    pass_c, sat_c;
  logic [REM_W-1:0]        rem, r2, det_ext;
  logic [QUO_W-1:0]        div_lo, quo;
  logic                    ge;

  // Best hit
  logic                    best_valid;
  logic [DIST_W-1:0]       best_distance;
  logic [IDX_W-1:0]        best_index;
  logic [IDX_W-1:0]        tri_count;
  logic [IDX_W:0]          cnt_inc;
  logic [DIST_W-1:0]       cand_dist;
  logic                    hit, take;
  logic                    nb_valid;
  logic [DIST_W-1:0]       nb_distance;
  logic [IDX_W-1:0]        nb_index;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      dir_x        <= '0;
      dir_y        <= '0;
      dir_z        <= -32'sd65536;
      min_distance <= 31'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x     <= cfg_data;
        REG_ORIGIN_Y: origin_y     <= cfg_data;
        REG_ORIGIN_Z: origin_z     <= cfg_data;
        REG_DIR_X:    dir_x        <= cfg_data;
        REG_DIR_Y:    dir_y        <= cfg_data;
        REG_DIR_Z:    dir_z        <= cfg_data;
        REG_MIN_DIST: min_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge and offset vectors on a new transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e1_x   <= SV_W'(in_data.b_x) - SV_W'(in_data.a_x);
      e1_y   <= SV_W'(in_data.b_y) - SV_W'(in_data.a_y);
      e1_z   <= SV_W'(in_data.b_z) - SV_W'(in_data.a_z);
      e2_x   <= SV_W'(in_data.c_x) - SV_W'(in_data.a_x);
      e2_y   <= SV_W'(in_data.c_y) - SV_W'(in_data.a_y);
      e2_z   <= SV_W'(in_data.c_z) - SV_W'(in_data.a_z);
      s_x    <= SV_W'(origin_x) - SV_W'(in_data.a_x);
      s_y    <= SV_W'(origin_y) - SV_W'(in_data.a_y);
      s_z    <= SV_W'(origin_z) - SV_W'(in_data.a_z);
      last_r <= in_data.last_triangle;
    end
  end

  // Operand select for the current product term
  always_comb begin
    uop = uop_rom(cmd.term);
    sv  = '0;
    case (uop.s_kind)
      SK_DIR: begin
        case (uop.s_comp)
          CX: sv = SV_W'(dir_x);
          CY: sv = SV_W'(dir_y);
          default: sv = SV_W'(dir_z);
        endcase
      end
      SK_E1: begin
        case (uop.s_comp)
          CX: sv = e1_x;
          CY: sv = e1_y;
          default: sv = e1_z;
        endcase
      end
      SK_E2: begin
        case (uop.s_comp)
          CX: sv = e2_x;
          CY: sv = e2_y;
          default: sv = e2_z;
        endcase
      end
      default: begin
        case (uop.s_comp)
          CX: sv = s_x;
          CY: sv = s_y;
          default: sv = s_z;
        endcase
      end
    endcase
    lv = '0;
    case (uop.l_kind)
      LK_E1: begin
        case (uop.l_comp)
          CX: lv = LV_W'(e1_x);
          CY: lv = LV_W'(e1_y);
          default: lv = LV_W'(e1_z);
        endcase
      end
      LK_E2: begin
        case (uop.l_comp)
          CX: lv = LV_W'(e2_x);
          CY: lv = LV_W'(e2_y);
          default: lv = LV_W'(e2_z);
        endcase
      end
      LK_P: begin
        case (uop.l_comp)
          CX: lv = LV_W'(p_x);
          CY: lv = LV_W'(p_y);
          default: lv = LV_W'(p_z);
        endcase
      end
      default: begin
        case (uop.l_comp)
          CX: lv = LV_W'(q_x);
          CY: lv = LV_W'(q_y);
          default: lv = LV_W'(q_z);
        endcase
      end
    endcase
    // low half unsigned, high half signed
    half_op = cmd.mul_hi ? {lv[LV_W-1], lv[LV_W-1:HALF_W]} : {1'b0, lv[HALF_W-1:0]};
  end

  // Product register with its accumulate tag
  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      t_dest  <= DST_NONE;
    end else begin
      t_valid <= cmd.mul_en;
      t_dest  <= (cmd.mul_en && cmd.mul_hi) ? uop.dest : DST_NONE;
    end
    prod_r  <= sv * half_op;
    t_hi    <= cmd.mul_hi;
    t_neg   <= uop.neg;
    t_first <= uop.first & ~cmd.mul_hi;
  end

  // Accumulate one partial product
  always_comb begin
    addend  = t_hi ? (ACC_W'(prod_r) <<< HALF_W) : ACC_W'(prod_r);
    base    = t_first ? '0 : acc;
    acc_new = t_neg ? base - addend : base + addend;
  end

  always_ff @(posedge clk) begin
    if (t_valid) begin
      acc <= acc_new;
      case (t_dest)
        DST_P0:   p_x  <= acc_new[P_W-1:0];
        DST_P1:   p_y  <= acc_new[P_W-1:0];
        DST_P2:   p_z  <= acc_new[P_W-1:0];
        DST_Q0:   q_x  <= acc_new[Q_W-1:0];
        DST_Q1:   q_y  <= acc_new[Q_W-1:0];
        DST_Q2:   q_z  <= acc_new[Q_W-1:0];
        DST_DET:  det  <= acc_new[N_W-1:0];
        DST_UNUM: unum <= acc_new[N_W-1:0];
        DST_VNUM: vnum <= acc_new[N_W-1:0];
        DST_TNUM: tnum <= acc_new[N_W-1:0];
        default: ;
      endcase
    end
  end

  // Sign fix: make det positive, numerators follow
  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      det_a <= det[N_W-1] ? -det  : det;
      u_a   <= det[N_W-1] ? -unum : unum;
      v_a   <= det[N_W-1] ? -vnum : vnum;
      t_a   <= det[N_W-1] ? -tnum : tnum;
    end
  end

  // Bound checks and saturation test
  always_comb begin
    uv_sum = (N_W+1)'(u_a) + (N_W+1)'(v_a);
    pass_c = (det_a != '0) && !u_a[N_W-1] && (u_a <= det_a) && !v_a[N_W-1] &&
             (uv_sum <= (N_W+1)'(det_a)) && !t_a[N_W-1] && (t_a != '0);
    // quotient of (t << 16) / det reaches 2^31
    sat_c  = SAT_W'($unsigned(t_a)) >= {det_a[N_W-1:0], 15'b0};
  end

  // Restoring division, one quotient bit per step
  always_comb begin
    det_ext = REM_W'(det_a[N_W-1:0]);
    r2      = {rem[REM_W-2:0], div_lo[QUO_W-1]};
    ge      = (r2 >= det_ext);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      pass_r <= pass_c;
      sat_r  <= sat_c;
      rem    <= REM_W'(t_a[N_W-1:15]);
      div_lo <= {t_a[14:0], 16'b0};
      quo    <= '0;
    end else if (cmd.div_step) begin
      rem    <= ge ? r2 - det_ext : r2;
      div_lo <= {div_lo[QUO_W-2:0], 1'b0};
      quo    <= {quo[QUO_W-2:0], ge};
    end
  end

  // Nearest hit selection
  always_comb begin
    cand_dist = sat_r ? DIST_MAX : quo;
    hit       = pass_r && (cand_dist > min_distance);
    take      = hit && (!best_valid || cand_dist < best_distance ||
                        (cand_dist == best_distance && tri_count < best_index));
    nb_valid    = best_valid | take;
    nb_distance = take ? cand_dist : best_distance;
    nb_index    = take ? tri_count : best_index;
    cnt_inc     = {1'b0, tri_count} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid    <= 1'b0;
      best_distance <= DIST_MAX;
      best_index    <= '0;
      tri_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      // a new result may land in the same cycle the old one is taken
      if (cmd.update && last_r) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.update) begin
        if (last_r) begin
          tri_count     <= '0;
          best_valid    <= 1'b0;
          best_distance <= DIST_MAX;
          best_index    <= '0;
        end else begin
          tri_count     <= (cnt_inc >= (IDX_W+1)'(TRI_LIMIT)) ? '0 : cnt_inc[IDX_W-1:0];
          best_valid    <= nb_valid;
          best_distance <= nb_distance;
          best_index    <= nb_index;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.update && last_r) begin
      out_data.hit_found    <= nb_valid;
      out_data.hit_distance <= nb_distance;
      out_data.hit_triangle <= nb_index;
    end
  end

  assign status.div_needed = pass_r & ~sat_r;
  assign status.last       = last_r;
  assign status.out_busy   = out_valid & out_stall;

`ifndef NO_ASSERTIONS
  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    !best_valid |-> best_distance == DIST_MAX && best_index == '0)
    else $error("best hit not cleared");
  a_store_on_hi: assert property (@(posedge clk) disable iff (rst)
    t_valid && t_dest != DST_NONE |-> t_hi) else $error("store before term complete");
  a_out_only_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.update) && $past(last_r))
    else $error("result without last triangle");
`endif
endmodule

@@ hw/rtl/ray_triangle_closest_hit.sv @@
// Closest-hit ray/triangle unit: top level joining controller and datapath.
//
// Triangles arrive one per transaction and are numbered from zero; each gets an
// exact Moller-Trumbore test against the ray held in the configuration
// registers, and the nearest hit (lower index on a tie) is kept. The triangle
// marked last produces one result and clears the running best. A triangle
// skips the divider when it fails the bound checks or its distance
// saturates, and otherwise has its distance divided out; the 24 product
// terms run through one shared 33x35-bit multiplier in two halves each,
// and the restoring divider produces one quotient bit per cycle. A
// finished result waits in its output register while the next
// triangle is already being worked on; a last triangle waits to write its
// result only if the previous one has not been taken. Configuration writes
// are always ready and must only be made while the unit is idle.
module ray_triangle_closest_hit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rtch_pkg::tri_in_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rtch_pkg::hit_out_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtch_pkg::COORD_W-1:0]   cfg_data
);
  import rtch_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  rtch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Arithmetic and result state
  rtch_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ tb/ray_triangle_closest_hit_checker.sv @@
// Checker for the closest-hit unit: tracks the ray registers, predicts results and compares.
module ray_triangle_closest_hit_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  rtch_pkg::tri_in_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  rtch_pkg::hit_out_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtch_pkg::COORD_W-1:0]   cfg_data,
  output int                             errors,
  output int                             pending
);
  import rtch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  // Shadow copy of the ray registers
  logic signed [COORD_W-1:0] ray_org [3];
  logic signed [COORD_W-1:0] ray_dir [3];
  logic [DIST_W-1:0]         near_limit;

  // Running closest hit of the current scene
  logic              best_hit;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  int                tri_num;

  hit_out_t expected_hits[$];

  // Exact Moller-Trumbore test; returns 1 on a hit above the near limit
  function automatic bit tri_distance(input tri_in_t t, output logic [DIST_W-1:0] tri_dist);
    wide_t d[3], e1[3], e2[3], s[3], p[3], q[3];
    wide_t det, un, vn, tn;
    logic [127:0] quo;
    d[0] = ray_dir[0];  d[1] = ray_dir[1];  d[2] = ray_dir[2];
    e1[0] = wide_t'($signed(t.b_x)) - $signed(t.a_x);
    e1[1] = wide_t'($signed(t.b_y)) - $signed(t.a_y);
    e1[2] = wide_t'($signed(t.b_z)) - $signed(t.a_z);
    e2[0] = wide_t'($signed(t.c_x)) - $signed(t.a_x);
    e2[1] = wide_t'($signed(t.c_y)) - $signed(t.a_y);
    e2[2] = wide_t'($signed(t.c_z)) - $signed(t.a_z);
    s[0] = wide_t'(ray_org[0]) - $signed(t.a_x);
    s[1] = wide_t'(ray_org[1]) - $signed(t.a_y);
    s[2] = wide_t'(ray_org[2]) - $signed(t.a_z);
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    tri_dist = '0;
    if (det == 0) return 1'b0;
    if (det < 0) begin
      det = -det;  un = -un;  vn = -vn;  tn = -tn;
    end
    if (un < 0 || un > det) return 1'b0;
    if (vn < 0 || un + vn > det) return 1'b0;
    if (tn <= 0) return 1'b0;
    quo = 128'(tn <<< 16) / 128'(det);
    tri_dist = (quo > 128'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
    return tri_dist > near_limit;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    logic [DIST_W-1:0] cand_dist;
    hit_out_t exp_hit, got;
    bit hit;
    if (rst) begin
      ray_org[0] = '0;  ray_org[1] = '0;  ray_org[2] = '0;
      ray_dir[0] = '0;  ray_dir[1] = '0;  ray_dir[2] = -32'sd65536;
      near_limit = 31'd7;
      best_hit = 1'b0;  best_dist = DIST_MAX;  best_idx = '0;  tri_num = 0;
      expected_hits.delete();
      errors = 0;
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X: ray_org[0] = cfg_data;
          REG_ORIGIN_Y: ray_org[1] = cfg_data;
          REG_ORIGIN_Z: ray_org[2] = cfg_data;
          REG_DIR_X:    ray_dir[0] = cfg_data;
          REG_DIR_Y:    ray_dir[1] = cfg_data;
          REG_DIR_Z:    ray_dir[2] = cfg_data;
          REG_MIN_DIST: near_limit = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      // triangle transaction
      if (in_valid && !in_stall) begin
        hit = tri_distance(in_data, cand_dist);
        if (hit && (!best_hit || cand_dist < best_dist ||
                    (cand_dist == best_dist && IDX_W'(tri_num) < best_idx))) begin
          best_hit = 1'b1;  best_dist = cand_dist;  best_idx = IDX_W'(tri_num);
        end
        tri_num = (tri_num + 1 >= TRI_LIMIT) ? 0 : tri_num + 1;
        if (in_data.last_triangle) begin
          exp_hit.hit_found = best_hit;
          exp_hit.hit_distance = best_dist;
          exp_hit.hit_triangle = best_idx;
          expected_hits = {expected_hits, exp_hit};
          best_hit = 1'b0;  best_dist = DIST_MAX;  best_idx = '0;  tri_num = 0;
        end
      end
      // result transaction
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_hits.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result found=%0b dist=%h tri=%0d",
                     got.hit_found, got.hit_distance, got.hit_triangle);
        end else begin
          exp_hit = expected_hits.pop_front();
          if (got.hit_found !== exp_hit.hit_found ||
              got.hit_distance !== exp_hit.hit_distance ||
              got.hit_triangle !== exp_hit.hit_triangle) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: exp found=%0b dist=%h tri=%0d, got found=%0b dist=%h tri=%0d",
                       exp_hit.hit_found, exp_hit.hit_distance, exp_hit.hit_triangle,
                       got.hit_found, got.hit_distance, got.hit_triangle);
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_ray_triangle_closest_hit.sv @@
// Testbench top for the closest-hit unit: stimulus, ray settings and verdict.
module tb_ray_triangle_closest_hit;
  import rtch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tri_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hit_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  int                   errors;
  int                   pending;

  // Current ray, mirrored here to aim well-formed triangles
  longint org[3];
  longint dir[3];
  bit     no_idle = 1'b0;
  int     tri_sent = 0;
  int     scenes = 0;
  int     settings = 0;

  ray_triangle_closest_hit uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ray_triangle_closest_hit_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always #1 clk = ~clk;

  // Receiver backpressure
  always @(negedge clk) out_stall <= !no_idle && ($urandom_range(99) < 23);

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx <= REG_DIR_Z) begin
      if (idx < REG_DIR_X) org[idx] = longint'($signed(val));
      else dir[idx - REG_DIR_X] = longint'($signed(val));
    end
  endtask

  // Drain all results, let the pipeline settle, then load a new ray
  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input logic [30:0] mind);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_DIR_X, dx);
    reg_write(REG_DIR_Y, dy);
    reg_write(REG_DIR_Z, dz);
    reg_write(REG_MIN_DIST, {1'b0, mind});
    settings++;
  endtask

  task automatic send_tri(input tri_in_t t);
    bit ok;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = t;
    do begin
      #0.5;
      ok = !in_stall;
      @(posedge clk);
      if (!ok) @(negedge clk);
    end while (!ok);
    tri_sent++;
    if (t.last_triangle) scenes++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic tri_in_t mk_tri(input longint ax, ay, az, bx, by, bz,
                                     cx, cy, cz, input bit last);
    tri_in_t t;
    t.a_x = ax[31:0];  t.a_y = ay[31:0];  t.a_z = az[31:0];
    t.b_x = bx[31:0];  t.b_y = by[31:0];  t.b_z = bz[31:0];
    t.c_x = cx[31:0];  t.c_y = cy[31:0];  t.c_z = cz[31:0];
    t.last_triangle = last;
    return t;
  endfunction

  // Triangle placed around a point on the ray, spanning x and y
  function automatic tri_in_t aimed_tri(input bit last);
    longint k, r, cx, cy, cz, jx, jy;
    tri_in_t t;
    k  = longint'($urandom_range(32'h0010_0000)) - 64'sd131072;
    r  = 64'd1 << $urandom_range(20, 12);
    r  = r + $urandom_range(int'(r));
    cx = org[0] + ((dir[0] * k) >>> 16);
    cy = org[1] + ((dir[1] * k) >>> 16);
    cz = org[2] + ((dir[2] * k) >>> 16);
    jx = $urandom_range(2 * r) - r;
    jy = $urandom_range(2 * r) - r;
    if ($urandom_range(1))
      t = mk_tri(cx - r + jx / 4, cy - r, cz + jy / 8, cx + r, cy - r + jy / 4, cz,
                 cx + jx / 2, cy + r, cz - jx / 8, last);
    else
      t = mk_tri(cx - r + jx / 4, cy - r, cz + jy / 8, cx + jx / 2, cy + r, cz - jx / 8,
                 cx + r, cy - r + jy / 4, cz, last);
    return t;
  endfunction

  function automatic tri_in_t noise_tri(input bit last);
    tri_in_t t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 1'b0};
    t.last_triangle = last;
    return t;
  endfunction

  // One scene: several triangles, duplicates now and then for the tie rule
  task automatic run_scene();
    int n;
    tri_in_t t, prev;
    n = $urandom_range(6, 1);
    prev = aimed_tri(1'b0);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(9) == 0) t = prev;
      else if ($urandom_range(99) < 75) t = aimed_tri(1'b0);
      else t = noise_tri(1'b0);
      t.last_triangle = (i == n - 1);
      send_tri(t);
      prev = t;
    end
  endtask

  localparam longint ONE = 64'sd65536;

  initial begin
    org[0] = 0;  org[1] = 0;  org[2] = 0;
    dir[0] = 0;  dir[1] = 0;  dir[2] = -ONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset ray straight down the negative z axis
    send_tri(mk_tri(-ONE, -ONE, -10 * ONE, ONE, -ONE, -10 * ONE, 0, ONE, -10 * ONE, 1));
    // triangle behind the origin gives a negative distance
    send_tri(mk_tri(-ONE, -ONE, 10 * ONE, ONE, -ONE, 10 * ONE, 0, ONE, 10 * ONE, 1));
    // distance zero: triangle passes through the origin
    send_tri(mk_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1));
    // degenerate triangle
    send_tri(mk_tri(5, 5, -ONE, 5, 5, -ONE, 5, 5, -ONE, 1));
    // ray through vertex a exactly, opposite winding
    send_tri(mk_tri(0, 0, -2 * ONE, 0, ONE, -2 * ONE, ONE, 0, -2 * ONE, 1));
    // field extremes
    send_tri(mk_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                    32'h7FFF_FFFF, -64'sd2147483648, 0, 1));
    // tie: equal distance twice, lower index wins, a farther one last; then a nearer one after
    send_tri(mk_tri(-ONE, -ONE, -3 * ONE, ONE, -ONE, -3 * ONE, 0, ONE, -3 * ONE, 0));
    send_tri(mk_tri(-ONE, -ONE, -3 * ONE, ONE, -ONE, -3 * ONE, 0, ONE, -3 * ONE, 0));
    send_tri(mk_tri(-ONE, -ONE, -5 * ONE, ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE, 1));
    send_tri(mk_tri(-ONE, -ONE, -4 * ONE, ONE, -ONE, -4 * ONE, 0, ONE, -4 * ONE, 0));
    send_tri(mk_tri(-ONE, -ONE, -2 * ONE, ONE, -ONE, -2 * ONE, 0, ONE, -2 * ONE, 1));

    // Saturating distance: far origin, tiny direction, no near limit
    set_ray(0, 0, 32'h7FFF_0000, 0, 0, 32'hFFFF_FFFF, 31'd0);
    send_tri(mk_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1));
    send_tri(mk_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0));
    send_tri(mk_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE, 1));
    // Zero direction and the largest near limit
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 31'h7FFF_FFFF);
    send_tri(noise_tri(1'b1));
    send_tri(aimed_tri(1'b1));
    // unknown register index is ignored; written only once the unit is idle
    wait (pending == 0);
    repeat (100) @(posedge clk);
    reg_write(REG_UNMAPPED, $urandom);
    send_tri(aimed_tri(1'b1));
    // far-away ray at full range, near limit at its largest
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_tri(aimed_tri(1'b0));
    send_tri(noise_tri(1'b1));

    // Random phases, each with its own ray
    while (tri_sent < 1100) begin
      case ($urandom_range(5))
        0: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   31'($urandom));
        1: set_ray($urandom_range(32'h0080_0000) - 32'h0040_0000, $urandom, $urandom,
                   0, 0, ($urandom_range(1) ? 32'(ONE) : 32'(-ONE)), 31'd0);
        default:
          set_ray($urandom_range(32'h0080_0000) - 32'h0040_0000,
                  $urandom_range(32'h0080_0000) - 32'h0040_0000,
                  $urandom_range(32'h0080_0000) - 32'h0040_0000,
                  $urandom_range(32'h8000) - 32'h4000,
                  $urandom_range(32'h8000) - 32'h4000,
                  ($urandom_range(1) ? 1 : -1) * int'($urandom_range(32'h2_0000, 32'h8000)),
                  31'($urandom_range(32'h2_0000)));
      endcase
      for (int s = 0; s < 25; s++) begin
        no_idle = (tri_sent >= 500 && tri_sent < 650);
        run_scene();
      end
    end
    no_idle = 1'b0;

    // Drain and let the pipeline go quiet
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d triangles in %0d scenes over %0d ray settings.",
             tri_sent, scenes, settings);
    $display("Checked closest-hit results with %0d mismatches, %0d left over.",
             errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
